>>> rtl/fpba_pkg.sv
// ============================================================================
// fpba_pkg: shared definitions for the fit-policy block allocator
// Holds codes, default sizes and the control group that travels along the
// row of block cells.
// ============================================================================
package fpba_pkg;

  localparam int NUM_BLOCKS_DEF = 16;
  localparam int SIZE_BITS_DEF  = 16;

  localparam int SLOT_BITS     = 4;
  localparam int AMT_BITS      = 16;
  localparam int STATUS_BITS   = 2;
  localparam int MODE_BITS     = 2;
  localparam int CNT_BITS      = 5;
  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = 8;

  localparam logic [CNT_BITS-1:0] CNT_RESET = 5'd16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_FIT_MODE    = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BLOCK_COUNT = 4'd1;

  typedef enum logic [MODE_BITS-1:0] {
    FIT_BEST  = 2'd0,
    FIT_NEXT  = 2'd1,
    FIT_FIRST = 2'd2
  } fit_mode_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_LOADED   = 2'd0,
    ST_GRANTED  = 2'd1,
    ST_NO_SPACE = 2'd2
  } status_e;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_ALLOC = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_HOLD = 2'd2
  } fsm_e;

  // Control part of the search token handed from cell to cell.
  typedef struct packed {
    logic valid;    // a search token sits in this stage
    logic best;     // best fit search (otherwise first or next fit)
    logic found_a;  // a fitting block at or after the start index was seen
    logic found_b;  // a fitting block anywhere was seen
  } tok_ctrl_t;

endpackage

>>> rtl/fpba_cell.sv
// ============================================================================
// fpba_cell: one block of the allocator table
// Holds the free space of one block, updates the passing search token with
// its own candidate, and registers the token before handing it to the next cell.
// ============================================================================
module fpba_cell #(
  parameter int  CELL_IDX   = 0,
  parameter int  NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
  parameter int  SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF,
  localparam int IdxW       = $clog2(NUM_BLOCKS)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [fpba_pkg::CNT_BITS-1:0] block_count_i,
  input  logic                          wr_en_i,
  input  logic [IdxW-1:0]               wr_idx_i,
  input  logic [SIZE_BITS-1:0]          wr_data_i,
  input  fpba_pkg::tok_ctrl_t           ctrl_i,
  input  logic [SIZE_BITS-1:0]          need_i,
  input  logic [IdxW-1:0]               start_i,
  input  logic [IdxW-1:0]               idx_a_i,
  input  logic [SIZE_BITS-1:0]          val_a_i,
  input  logic [IdxW-1:0]               idx_b_i,
  input  logic [SIZE_BITS-1:0]          val_b_i,
  output fpba_pkg::tok_ctrl_t           ctrl_o,
  output logic [SIZE_BITS-1:0]          need_o,
  output logic [IdxW-1:0]               start_o,
  output logic [IdxW-1:0]               idx_a_o,
  output logic [SIZE_BITS-1:0]          val_a_o,
  output logic [IdxW-1:0]               idx_b_o,
  output logic [SIZE_BITS-1:0]          val_b_o
);
  import fpba_pkg::*;

  localparam int CntW = $clog2(NUM_BLOCKS + 1);
  localparam int CmpW = (CntW > CNT_BITS) ? CntW : CNT_BITS;
  localparam logic [IdxW-1:0] MyIdx = IdxW'(CELL_IDX);

  logic [SIZE_BITS-1:0] free_q;
  tok_ctrl_t            ctrl_q;
  logic [SIZE_BITS-1:0] need_q;
  logic [IdxW-1:0]      start_q;
  logic [IdxW-1:0]      idx_a_q;
  logic [SIZE_BITS-1:0] val_a_q;
  logic [IdxW-1:0]      idx_b_q;
  logic [SIZE_BITS-1:0] val_b_q;

  logic active;
  logic fits;
  logic upd_a;
  logic upd_b;

  always_comb begin
    active = CmpW'(CELL_IDX) < CmpW'(block_count_i);
    fits   = active && (free_q >= need_i);
    // Candidate a: first fit at or after the start index (next and first fit).
    upd_a  = ctrl_i.valid && fits && (MyIdx >= start_i) && !ctrl_i.found_a;
    // Candidate b: first fit overall, or the strictly smaller block in best fit.
    upd_b  = ctrl_i.valid && fits &&
             (!ctrl_i.found_b || (ctrl_i.best && (free_q < val_b_i)));
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_idx_i == MyIdx)) begin
      free_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q.valid   <= ctrl_i.valid;
      ctrl_q.best    <= ctrl_i.best;
      ctrl_q.found_a <= ctrl_i.found_a || upd_a;
      ctrl_q.found_b <= ctrl_i.found_b || upd_b;
    end
  end

  always_ff @(posedge clk_i) begin
    need_q  <= need_i;
    start_q <= start_i;
    idx_a_q <= upd_a ? MyIdx  : idx_a_i;
    val_a_q <= upd_a ? free_q : val_a_i;
    idx_b_q <= upd_b ? MyIdx  : idx_b_i;
    val_b_q <= upd_b ? free_q : val_b_i;
  end

  assign ctrl_o  = ctrl_q;
  assign need_o  = need_q;
  assign start_o = start_q;
  assign idx_a_o = idx_a_q;
  assign val_a_o = val_a_q;
  assign idx_b_o = idx_b_q;
  assign val_b_o = val_b_q;

endmodule

>>> rtl/fit_policy_block_allocator_unit.sv
// ============================================================================
// fit_policy_block_allocator_unit: best, next and first fit block allocator
// Keeps the free space of a table of blocks in a row of cells and grants
// allocation requests under the configured fit policy.
// ============================================================================
// A load transaction writes one block's size, and its result passes through
// the result register into the output register. An allocation request
// launches a search token into the row of block cells; the token moves one
// cell per clock, and as it leaves the last cell the granted block is written
// back and the result is registered on its way into the output register.
// One transaction is worked on at a time; the next one is accepted as soon as
// the previous result has moved into the output register, even while that
// result still waits there. Configuration writes are always accepted and must
// only be issued while the unit is idle.
module fit_policy_block_allocator_unit #(
  parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [fpba_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [fpba_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               req_type_i,
  input  logic [fpba_pkg::SLOT_BITS-1:0]     block_slot_i,
  input  logic [fpba_pkg::AMT_BITS-1:0]      amount_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [fpba_pkg::STATUS_BITS-1:0]   status_o,
  output logic [fpba_pkg::SLOT_BITS-1:0]     granted_block_o,
  output logic [fpba_pkg::AMT_BITS-1:0]      space_left_o
);
  import fpba_pkg::*;

  localparam int IdxW = $clog2(NUM_BLOCKS);
  localparam int CntW = $clog2(NUM_BLOCKS + 1);
  localparam int CmpW = (CntW > CNT_BITS) ? CntW : CNT_BITS;

  // Wraps a slot number into the table by repeated subtraction.
  function automatic logic [IdxW-1:0] wrap_slot(input logic [SLOT_BITS-1:0] v);
    logic [8:0] r;
    r = 9'(v);
    for (int i = 0; i < 8; i++) begin
      if (r >= 9'(NUM_BLOCKS)) begin
        r = r - 9'(NUM_BLOCKS);
      end
    end
    return r[IdxW-1:0];
  endfunction

  // Configuration registers and scan pointer.
  logic [MODE_BITS-1:0] fit_mode_q;
  logic [CNT_BITS-1:0]  block_count_q;
  logic [IdxW-1:0]      ptr_q;
  logic [IdxW-1:0]      ptr_d;

  fsm_e state_q;
  fsm_e state_d;

  // Token chain: stage 0 is the launch, stage k+1 the output of cell k.
  tok_ctrl_t            ctrl_c  [NUM_BLOCKS+1];
  logic [SIZE_BITS-1:0] need_c  [NUM_BLOCKS+1];
  logic [IdxW-1:0]      start_c [NUM_BLOCKS+1];
  logic [IdxW-1:0]      idx_a_c [NUM_BLOCKS+1];
  logic [SIZE_BITS-1:0] val_a_c [NUM_BLOCKS+1];
  logic [IdxW-1:0]      idx_b_c [NUM_BLOCKS+1];
  logic [SIZE_BITS-1:0] val_b_c [NUM_BLOCKS+1];
  logic [NUM_BLOCKS-1:0] tok_valid;

  logic [SIZE_BITS+AMT_BITS-1:0] amt_ext;
  logic [SIZE_BITS-1:0]          need;
  logic [IdxW-1:0]               slot;
  logic [IdxW-1:0]               start;
  logic                          is_best;
  logic                          launch;

  logic                 pick_found;
  logic [IdxW-1:0]      pick_idx;
  logic [SIZE_BITS-1:0] pick_val;
  logic [SIZE_BITS-1:0] grant_space;

  logic                 wr_en;
  logic [IdxW-1:0]      wr_idx;
  logic [SIZE_BITS-1:0] wr_data;

  logic                 res_set;
  status_e              res_status_d;
  logic [IdxW-1:0]      res_idx_d;
  logic [SIZE_BITS-1:0] res_val_d;
  status_e              res_status_q;
  logic [IdxW-1:0]      res_idx_q;
  logic [SIZE_BITS-1:0] res_val_q;

  logic                 out_load;
  logic                 out_valid_q;
  status_e              out_status_q;
  logic [IdxW-1:0]      out_idx_q;
  logic [SIZE_BITS-1:0] out_val_q;
  logic [IdxW+SLOT_BITS-1:0]     idx_ext;
  logic [SIZE_BITS+AMT_BITS-1:0] val_ext;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q    <= FIT_BEST;
      block_count_q <= CNT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FIT_MODE:    fit_mode_q    <= cfg_data_i[MODE_BITS-1:0];
        CFG_BLOCK_COUNT: block_count_q <= cfg_data_i[CNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Input conversion and search launch values.
  always_comb begin
    amt_ext = {{SIZE_BITS{1'b0}}, amount_i};
    need    = amt_ext[SIZE_BITS-1:0];
    slot    = wrap_slot(block_slot_i);
    start   = '0;
    is_best = 1'b0;
    case (fit_mode_q)
      FIT_BEST: is_best = 1'b1;
      FIT_NEXT: begin
        // A pointer at or beyond the active count restarts at block 0.
        if (CmpW'(ptr_q) < CmpW'(block_count_q)) begin
          start = ptr_q;
        end
      end
      FIT_FIRST: ;
      default: ;
    endcase
  end

  assign ctrl_c[0]  = '{valid: launch, best: is_best, found_a: 1'b0, found_b: 1'b0};
  assign need_c[0]  = need;
  assign start_c[0] = start;
  assign idx_a_c[0] = '0;
  assign val_a_c[0] = '0;
  assign idx_b_c[0] = '0;
  assign val_b_c[0] = '0;

  for (genvar k = 0; k < NUM_BLOCKS; k++) begin : g_cell
    fpba_cell #(
      .CELL_IDX   (k),
      .NUM_BLOCKS (NUM_BLOCKS),
      .SIZE_BITS  (SIZE_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .block_count_i (block_count_q),
      .wr_en_i       (wr_en),
      .wr_idx_i      (wr_idx),
      .wr_data_i     (wr_data),
      .ctrl_i        (ctrl_c[k]),
      .need_i        (need_c[k]),
      .start_i       (start_c[k]),
      .idx_a_i       (idx_a_c[k]),
      .val_a_i       (val_a_c[k]),
      .idx_b_i       (idx_b_c[k]),
      .val_b_i       (val_b_c[k]),
      .ctrl_o        (ctrl_c[k+1]),
      .need_o        (need_c[k+1]),
      .start_o       (start_c[k+1]),
      .idx_a_o       (idx_a_c[k+1]),
      .val_a_o       (val_a_c[k+1]),
      .idx_b_o       (idx_b_c[k+1]),
      .val_b_o       (val_b_c[k+1])
    );
    assign tok_valid[k] = ctrl_c[k+1].valid;
  end

  // Choice at the end of the row. Next and first fit prefer a block at or
  // after the start index and otherwise wrap to the first fit overall.
  always_comb begin
    if (ctrl_c[NUM_BLOCKS].best || ctrl_c[NUM_BLOCKS].found_a == 1'b0) begin
      pick_found = ctrl_c[NUM_BLOCKS].found_b;
      pick_idx   = idx_b_c[NUM_BLOCKS];
      pick_val   = val_b_c[NUM_BLOCKS];
    end else begin
      pick_found = 1'b1;
      pick_idx   = idx_a_c[NUM_BLOCKS];
      pick_val   = val_a_c[NUM_BLOCKS];
    end
    grant_space = pick_val - need_c[NUM_BLOCKS];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (req_type_i == REQ_LOAD) ? S_HOLD : S_SCAN;
        end
      end
      S_SCAN: begin
        if (ctrl_c[NUM_BLOCKS].valid) begin
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready_o   = 1'b0;
    launch       = 1'b0;
    wr_en        = 1'b0;
    wr_idx       = slot;
    wr_data      = need;
    res_set      = 1'b0;
    res_status_d = ST_LOADED;
    res_idx_d    = slot;
    res_val_d    = need;
    ptr_d        = ptr_q;
    out_load     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (req_type_i == REQ_LOAD) begin
            wr_en   = 1'b1;
            res_set = 1'b1;
          end else begin
            launch = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (ctrl_c[NUM_BLOCKS].valid) begin
          res_set = 1'b1;
          wr_idx  = pick_idx;
          wr_data = grant_space;
          if (pick_found) begin
            wr_en        = 1'b1;
            res_status_d = ST_GRANTED;
            res_idx_d    = pick_idx;
            res_val_d    = grant_space;
          end else begin
            res_status_d = ST_NO_SPACE;
            res_idx_d    = '0;
            res_val_d    = '0;
          end
          // On failure the pointer lands back where the circular scan began.
          if (fit_mode_q == FIT_NEXT) begin
            ptr_d = pick_found ? pick_idx : start_c[NUM_BLOCKS];
          end
        end
      end
      S_HOLD: out_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_set) begin
      res_status_q <= res_status_d;
      res_idx_q    <= res_idx_d;
      res_val_q    <= res_val_d;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_idx_q    <= res_idx_q;
      out_val_q    <= res_val_q;
    end
  end

  always_comb begin
    idx_ext = {{SLOT_BITS{1'b0}}, out_idx_q};
    val_ext = {{AMT_BITS{1'b0}}, out_val_q};
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign granted_block_o = idx_ext[SLOT_BITS-1:0];
  assign space_left_o    = val_ext[AMT_BITS-1:0];

  // Exactly one search token is in the row while scanning, none otherwise.
  a_single_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(tok_valid) == ((state_q == S_SCAN) ? 1 : 0))
    else $error("search token count does not match the scan state");

  // A grant only writes back a block inside the active count.
  a_grant_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && state_q == S_SCAN) |-> (CmpW'(wr_idx) < CmpW'(block_count_q)))
    else $error("grant write-back outside the active blocks");

  // The scan pointer always names an existing block.
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(ptr_q) < CmpW'(NUM_BLOCKS))
    else $error("scan pointer beyond the block table");

  // A failed request reports neither a block nor any space.
  a_no_space_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == ST_NO_SPACE) |-> (out_idx_q == '0 && out_val_q == '0))
    else $error("no-space result carries a block or space value");

endmodule
